/* rtl/core/qav_pkg.sv */
// ----------------------------------------------------------------------------
// qav_pkg
// shared types, widths and constants of the angular velocity block
// ----------------------------------------------------------------------------
`default_nettype none

package qav_pkg;

  // vector part and norm, integer with 28 fractional bits
  localparam int D_W = 32;
  localparam int NORM_W = 32;
  // cordic working widths
  localparam int XY_W = 40;
  localparam int Z_W = 34;
  localparam int THETA_W = Z_W + 1;
  // divider quotient width and useful ratio width
  localparam int QUOT_W = 36;
  localparam int RATIO_W = 29;
  localparam int FRAC_BITS = 28;
  localparam int TS_W = 16;
  localparam int RATE_W = 32;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [Z_W-1:0] ANGLE_HALF_PI = 34'd1686629713;
  localparam logic [TS_W-1:0] TIME_STEP_RESET = 16'd6554;

  typedef struct packed {
    logic signed [D_W-1:0] d_x;
    logic signed [D_W-1:0] d_y;
    logic signed [D_W-1:0] d_z;
    logic [NORM_W-1:0] norm;
    logic signed [THETA_W-1:0] theta;
    logic zero;
  } qav_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qav_queue_status_t;

  // arctangent of 2^-i in Q2.30, rounded to nearest
  function automatic logic [Z_W-1:0] arctan_q30(input logic [4:0] idx);
    logic [Z_W-1:0] v;
    unique case (idx)
      5'd0: v = 34'd843314857;
      5'd1: v = 34'd497837829;
      5'd2: v = 34'd263043837;
      5'd3: v = 34'd133525159;
      5'd4: v = 34'd67021687;
      5'd5: v = 34'd33543516;
      5'd6: v = 34'd16775851;
      5'd7: v = 34'd8388437;
      5'd8: v = 34'd4194283;
      5'd9: v = 34'd2097149;
      5'd10: v = 34'd1048576;
      5'd11: v = 34'd524288;
      5'd12: v = 34'd262144;
      5'd13: v = 34'd131072;
      5'd14: v = 34'd65536;
      5'd15: v = 34'd32768;
      5'd16: v = 34'd16384;
      5'd17: v = 34'd8192;
      5'd18: v = 34'd4096;
      5'd19: v = 34'd2048;
      5'd20: v = 34'd1024;
      5'd21: v = 34'd512;
      5'd22: v = 34'd256;
      5'd23: v = 34'd128;
      5'd24: v = 34'd64;
      5'd25: v = 34'd32;
      5'd26: v = 34'd16;
      5'd27: v = 34'd8;
      5'd28: v = 34'd4;
      5'd29: v = 34'd2;
      5'd30: v = 34'd1;
      5'd31: v = 34'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/qav_front.sv */
// ----------------------------------------------------------------------------
// qav_front
// quaternion difference, vector norm and cordic angle pipeline
// ----------------------------------------------------------------------------
`default_nettype none

module qav_front #(
  parameter int COMPONENT_WIDTH = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic accept,
  input  logic signed [COMPONENT_WIDTH-1:0] first_w,
  input  logic signed [COMPONENT_WIDTH-1:0] first_x,
  input  logic signed [COMPONENT_WIDTH-1:0] first_y,
  input  logic signed [COMPONENT_WIDTH-1:0] first_z,
  input  logic signed [COMPONENT_WIDTH-1:0] second_w,
  input  logic signed [COMPONENT_WIDTH-1:0] second_x,
  input  logic signed [COMPONENT_WIDTH-1:0] second_y,
  input  logic signed [COMPONENT_WIDTH-1:0] second_z,
  input  logic force_short_path,
  output logic out_valid,
  output qav_pkg::qav_item_t out_item
);

  localparam int CW = COMPONENT_WIDTH;
  localparam int PW = 2 * COMPONENT_WIDTH;
  localparam int DW = qav_pkg::D_W;
  localparam int XW = qav_pkg::XY_W;
  localparam int ZW = qav_pkg::Z_W;

  // product scaled to the q2.62 frame, optionally negated, floored by 4
  function automatic logic signed [63:0] term(input logic signed [PW-1:0] p, input logic neg);
    logic signed [63:0] wide;
    wide = 64'(p) <<< (64 - PW);
    if (neg) begin
      wide = -wide;
    end
    return wide >>> 2;
  endfunction

  // stage 0: loaded components
  logic signed [CW-1:0] a [4];
  logic signed [CW-1:0] b [4];
  logic flag0, v0;

  always_ff @(posedge clk) begin
    if (accept) begin
      a[0] <= first_w;  a[1] <= first_x;  a[2] <= first_y;  a[3] <= first_z;
      b[0] <= second_w; b[1] <= second_x; b[2] <= second_y; b[3] <= second_z;
      flag0 <= force_short_path;
    end
  end

  // stage 1: all sixteen products a_i * b_j
  logic signed [PW-1:0] p1 [4][4];
  logic flag1, v1;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        p1[i][j] <= a[i] * b[j];
      end
    end
    flag1 <= flag0;
  end

  // stage 2: dot product sign decides shortest path negation
  logic signed [PW-1:0] p2 [4][4];
  logic neg2, v2;
  logic signed [63:0] dot;

  always_comb begin
    dot = term(p1[0][0], 1'b0) + term(p1[1][1], 1'b0)
        + term(p1[2][2], 1'b0) + term(p1[3][3], 1'b0);
  end

  always_ff @(posedge clk) begin
    p2 <= p1;
    neg2 <= flag1 & dot[63];
  end

  // stage 3: dq = q2 * conj(q1), floored to 28 fractional bits
  logic signed [63:0] sum_w, sum_x, sum_y, sum_z;
  logic signed [DW-1:0] dw3, dx3, dy3, dz3;
  logic v3;

  always_comb begin
    sum_w = term(p2[0][0], neg2) + term(p2[1][1], neg2)
          + term(p2[2][2], neg2) + term(p2[3][3], neg2);
    sum_x = -term(p2[1][0], neg2) + term(p2[0][1], neg2)
          - term(p2[3][2], neg2) + term(p2[2][3], neg2);
    sum_y = -term(p2[2][0], neg2) + term(p2[3][1], neg2)
          + term(p2[0][2], neg2) - term(p2[1][3], neg2);
    sum_z = -term(p2[3][0], neg2) - term(p2[2][1], neg2)
          + term(p2[1][2], neg2) + term(p2[0][3], neg2);
  end

  always_ff @(posedge clk) begin
    dw3 <= sum_w[63:32];
    dx3 <= sum_x[63:32];
    dy3 <= sum_y[63:32];
    dz3 <= sum_z[63:32];
  end

  // stage 4: squares of the vector part
  logic signed [63:0] sqx, sqy, sqz;
  logic signed [DW-1:0] dw4, dx4, dy4, dz4;
  logic v4;

  always_ff @(posedge clk) begin
    sqx <= dx3 * dx3;
    sqy <= dy3 * dy3;
    sqz <= dz3 * dz3;
    dw4 <= dw3; dx4 <= dx3; dy4 <= dy3; dz4 <= dz3;
  end

  // stage 5: sum of squares
  logic [63:0] ss5;
  logic signed [DW-1:0] dw5, dx5, dy5, dz5;
  logic v5;

  always_ff @(posedge clk) begin
    ss5 <= 64'(sqx) + 64'(sqy) + 64'(sqz);
    dw5 <= dw4; dx5 <= dx4; dy5 <= dy4; dz5 <= dz4;
  end

  // square root, one result bit per stage
  logic [63:0] rv [33];
  logic [63:0] rr [33];
  logic signed [DW-1:0] rw [33];
  logic signed [DW-1:0] rx [33];
  logic signed [DW-1:0] ry [33];
  logic signed [DW-1:0] rz [33];
  logic rvalid [33];

  assign rv[0] = ss5;
  assign rr[0] = '0;
  assign rw[0] = dw5;
  assign rx[0] = dx5;
  assign ry[0] = dy5;
  assign rz[0] = dz5;
  assign rvalid[0] = v5;

  for (genvar s = 0; s < 32; s++) begin : g_root
    localparam logic [63:0] RootBit = 64'd1 << (2 * (31 - s));
    logic [63:0] trial;
    assign trial = rr[s] + RootBit;
    always_ff @(posedge clk) begin
      if (rv[s] >= trial) begin
        rv[s+1] <= rv[s] - trial;
        rr[s+1] <= (rr[s] >> 1) + RootBit;
      end else begin
        rv[s+1] <= rv[s];
        rr[s+1] <= rr[s] >> 1;
      end
      rw[s+1] <= rw[s];
      rx[s+1] <= rx[s];
      ry[s+1] <= ry[s];
      rz[s+1] <= rz[s];
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        rvalid[s+1] <= 1'b0;
      end else begin
        rvalid[s+1] <= rvalid[s];
      end
    end
  end

  // cordic vectoring on (dq.w, norm)
  logic signed [XW-1:0] cx [CORDIC_STEPS+1];
  logic signed [XW-1:0] cy [CORDIC_STEPS+1];
  logic signed [ZW-1:0] cz [CORDIC_STEPS+1];
  qav_pkg::qav_item_t cside [CORDIC_STEPS+1];
  logic cvalid [CORDIC_STEPS+1];
  logic [qav_pkg::NORM_W-1:0] norm;

  assign norm = rr[32][qav_pkg::NORM_W-1:0];

  always_ff @(posedge clk) begin
    if (rw[32] < 0) begin
      cx[0] <= XW'(norm);
      cy[0] <= -XW'(rw[32]);
      cz[0] <= qav_pkg::ANGLE_HALF_PI;
    end else begin
      cx[0] <= XW'(rw[32]);
      cy[0] <= XW'(norm);
      cz[0] <= '0;
    end
    cside[0].d_x <= rx[32];
    cside[0].d_y <= ry[32];
    cside[0].d_z <= rz[32];
    cside[0].norm <= norm;
    cside[0].theta <= '0;
    cside[0].zero <= (norm == '0);
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    logic signed [XW-1:0] xs, ys;
    assign xs = cx[i] >>> i;
    assign ys = cy[i] >>> i;
    always_ff @(posedge clk) begin
      if (cy[i] > 0) begin
        cx[i+1] <= cx[i] + ys;
        cy[i+1] <= cy[i] - xs;
        cz[i+1] <= cz[i] + qav_pkg::arctan_q30(5'(i));
      end else begin
        cx[i+1] <= cx[i] - ys;
        cy[i+1] <= cy[i] + xs;
        cz[i+1] <= cz[i] - qav_pkg::arctan_q30(5'(i));
      end
      cside[i+1] <= cside[i];
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        cvalid[i+1] <= 1'b0;
      end else begin
        cvalid[i+1] <= cvalid[i];
      end
    end
  end

  // theta = 2 z; a zero norm or a non-positive angle gives a zero rate
  always_ff @(posedge clk) begin
    out_item.d_x <= cside[CORDIC_STEPS].d_x;
    out_item.d_y <= cside[CORDIC_STEPS].d_y;
    out_item.d_z <= cside[CORDIC_STEPS].d_z;
    out_item.norm <= cside[CORDIC_STEPS].norm;
    out_item.theta <= {cz[CORDIC_STEPS], 1'b0};
    out_item.zero <= cside[CORDIC_STEPS].zero | (cz[CORDIC_STEPS] <= 0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0; v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0; v5 <= 1'b0;
      cvalid[0] <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v0 <= accept; v1 <= v0; v2 <= v1; v3 <= v2; v4 <= v3; v5 <= v4;
      cvalid[0] <= rvalid[32];
      out_valid <= cvalid[CORDIC_STEPS];
    end
  end

endmodule

`default_nettype wire

/* rtl/core/qav_queue.sv */
// ----------------------------------------------------------------------------
// qav_queue
// short item queue between the angle pipeline and the rate pipeline
// ----------------------------------------------------------------------------
`default_nettype none

module qav_queue (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  qav_pkg::qav_item_t push_item,
  input  logic pop,
  output qav_pkg::qav_item_t head_item,
  output qav_pkg::qav_queue_status_t status
);

  localparam int DEPTH = qav_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);

  qav_pkg::qav_item_t store [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [PTR_W:0] count;

  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= push_item;
    end
  end

  assign head_item = store[rd_ptr];
  assign status.empty = (count == '0);
  assign status.full = (count == (PTR_W+1)'(DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
    end
  end

endmodule

`default_nettype wire

/* rtl/core/qav_div.sv */
// ----------------------------------------------------------------------------
// qav_div
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
`default_nettype none

module qav_div #(
  parameter int DIVIDEND_W = 60,
  parameter int DIVISOR_W = 32,
  parameter int QUOT_W = 36
) (
  input  logic clk,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0] divisor,
  output logic [QUOT_W-1:0] quotient
);

  // the user keeps upper dividend bits below the divisor; not enforced here
  logic [DIVISOR_W-1:0] rem [QUOT_W+1];
  logic [QUOT_W-1:0] low [QUOT_W+1];
  logic [DIVISOR_W-1:0] dv [QUOT_W+1];

  assign rem[0] = DIVISOR_W'(dividend >> QUOT_W);
  assign low[0] = dividend[QUOT_W-1:0];
  assign dv[0] = divisor;

  for (genvar s = 0; s < QUOT_W; s++) begin : g_step
    logic [DIVISOR_W:0] cat;
    logic ge;
    assign cat = {rem[s], low[s][QUOT_W-1]};
    assign ge = (cat >= {1'b0, dv[s]});
    always_ff @(posedge clk) begin
      rem[s+1] <= ge ? DIVISOR_W'(cat - {1'b0, dv[s]}) : DIVISOR_W'(cat);
      low[s+1] <= {low[s][QUOT_W-2:0], ge};
      dv[s+1] <= dv[s];
    end
  end

  assign quotient = low[QUOT_W];

endmodule

`default_nettype wire

/* rtl/core/qav_back.sv */
// ----------------------------------------------------------------------------
// qav_back
// rate pipeline: angle over time step, component over norm, scale, saturate
// ----------------------------------------------------------------------------
`default_nettype none

module qav_back (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  qav_pkg::qav_item_t in_item,
  input  logic [qav_pkg::TS_W-1:0] time_step,
  output logic done,
  output logic signed [qav_pkg::RATE_W-1:0] rate_x,
  output logic signed [qav_pkg::RATE_W-1:0] rate_y,
  output logic signed [qav_pkg::RATE_W-1:0] rate_z,
  output logic saturated
);

  localparam int QW = qav_pkg::QUOT_W;
  localparam int DW = qav_pkg::D_W;
  localparam int RW = qav_pkg::RATIO_W;
  localparam int FB = qav_pkg::FRAC_BITS;
  localparam int NW = qav_pkg::NORM_W;
  localparam int TW = qav_pkg::TS_W;
  localparam int RATE_W = qav_pkg::RATE_W;
  localparam int HALF = QW / 2;
  localparam int PPW = RW + HALF;

  // magnitude of a component and the ratio-dividend
  function automatic logic [DW+FB-1:0] scaled_mag(input logic signed [DW-1:0] d);
    logic [DW-1:0] mag;
    mag = d[DW-1] ? DW'(-d) : DW'(d);
    return {mag, {FB{1'b0}}};
  endfunction

  // clip |rate| and apply the sign: {flag, value}
  function automatic logic [RATE_W:0] clip(input logic [QW-1:0] m, input logic neg);
    logic [RATE_W-1:0] v;
    logic f;
    f = 1'b0;
    if (neg) begin
      if (m > QW'(64'h8000_0000)) begin
        v = 32'h8000_0000;
        f = 1'b1;
      end else begin
        v = -m[RATE_W-1:0];
      end
    end else begin
      if (m > QW'(64'h7FFF_FFFF)) begin
        v = 32'h7FFF_FFFF;
        f = 1'b1;
      end else begin
        v = m[RATE_W-1:0];
      end
    end
    return {f, v};
  endfunction

  logic [TW-1:0] dt;
  logic [QW-1:0] q_div, rx_div, ry_div, rz_div;

  assign dt = (time_step == '0) ? TW'(1) : time_step;

  qav_div #(.DIVIDEND_W(QW + 4), .DIVISOR_W(TW), .QUOT_W(QW)) u_div_q (
    .clk(clk),
    .dividend((QW + 4)'({in_item.theta[qav_pkg::Z_W-1:0], 2'b00})),
    .divisor(dt),
    .quotient(q_div)
  );

  qav_div #(.DIVIDEND_W(DW + FB), .DIVISOR_W(NW), .QUOT_W(QW)) u_div_x (
    .clk(clk), .dividend(scaled_mag(in_item.d_x)), .divisor(in_item.norm),
    .quotient(rx_div)
  );

  qav_div #(.DIVIDEND_W(DW + FB), .DIVISOR_W(NW), .QUOT_W(QW)) u_div_y (
    .clk(clk), .dividend(scaled_mag(in_item.d_y)), .divisor(in_item.norm),
    .quotient(ry_div)
  );

  qav_div #(.DIVIDEND_W(DW + FB), .DIVISOR_W(NW), .QUOT_W(QW)) u_div_z (
    .clk(clk), .dividend(scaled_mag(in_item.d_z)), .divisor(in_item.norm),
    .quotient(rz_div)
  );

  // sideband through the divider latency: {zero, sign x, sign y, sign z}
  logic [3:0] side [QW+1];
  logic sval [QW+1];

  assign side[0] = {in_item.zero, in_item.d_x[DW-1], in_item.d_y[DW-1], in_item.d_z[DW-1]};
  assign sval[0] = in_valid;

  for (genvar s = 0; s < QW; s++) begin : g_side
    always_ff @(posedge clk) begin
      side[s+1] <= side[s];
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        sval[s+1] <= 1'b0;
      end else begin
        sval[s+1] <= sval[s];
      end
    end
  end

  // partial products of ratio and angle rate, split at half the quotient
  logic [PPW-1:0] phx, plx, phy, ply, phz, plz;
  logic [3:0] side_m;
  logic val_m;

  always_ff @(posedge clk) begin
    phx <= rx_div[RW-1:0] * q_div[QW-1:HALF];
    plx <= rx_div[RW-1:0] * q_div[HALF-1:0];
    phy <= ry_div[RW-1:0] * q_div[QW-1:HALF];
    ply <= ry_div[RW-1:0] * q_div[HALF-1:0];
    phz <= rz_div[RW-1:0] * q_div[QW-1:HALF];
    plz <= rz_div[RW-1:0] * q_div[HALF-1:0];
    side_m <= side[QW];
  end

  logic [63:0] px, py, pz;
  logic [RATE_W:0] cx, cy, cz;

  always_comb begin
    px = (64'(phx) << HALF) + 64'(plx);
    py = (64'(phy) << HALF) + 64'(ply);
    pz = (64'(phz) << HALF) + 64'(plz);
    cx = clip(px[FB+QW-1:FB], side_m[2]);
    cy = clip(py[FB+QW-1:FB], side_m[1]);
    cz = clip(pz[FB+QW-1:FB], side_m[0]);
  end

  always_ff @(posedge clk) begin
    if (side_m[3]) begin
      rate_x <= '0;
      rate_y <= '0;
      rate_z <= '0;
      saturated <= 1'b0;
    end else begin
      rate_x <= cx[RATE_W-1:0];
      rate_y <= cy[RATE_W-1:0];
      rate_z <= cz[RATE_W-1:0];
      saturated <= cx[RATE_W] | cy[RATE_W] | cz[RATE_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      val_m <= 1'b0;
      done <= 1'b0;
    end else begin
      val_m <= sval[QW];
      done <= val_m;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/quaternion_angular_velocity.sv */
// ----------------------------------------------------------------------------
// quaternion_angular_velocity
// angular velocity from the difference of two orientation quaternions
// ----------------------------------------------------------------------------
// throughput: one item per cycle while busy is low, set by the fully
//   pipelined root, cordic and divider stages; the receiver cannot stall,
//   so done is never held off
// busy rises only when the in-flight credit count reaches its limit
// reset: synchronous, clears all valid and count state, time_step -> 6554
`default_nettype none

module quaternion_angular_velocity #(
  parameter int COMPONENT_WIDTH = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic clk,
  input  logic rst,
  // item input
  input  logic start,
  output logic busy,
  input  logic signed [COMPONENT_WIDTH-1:0] first_w,
  input  logic signed [COMPONENT_WIDTH-1:0] first_x,
  input  logic signed [COMPONENT_WIDTH-1:0] first_y,
  input  logic signed [COMPONENT_WIDTH-1:0] first_z,
  input  logic signed [COMPONENT_WIDTH-1:0] second_w,
  input  logic signed [COMPONENT_WIDTH-1:0] second_x,
  input  logic signed [COMPONENT_WIDTH-1:0] second_y,
  input  logic signed [COMPONENT_WIDTH-1:0] second_z,
  input  logic force_short_path,
  // time step register
  input  logic time_step_we,
  input  logic [qav_pkg::TS_W-1:0] time_step_wdata,
  // result
  output logic done,
  output logic signed [qav_pkg::RATE_W-1:0] rate_x,
  output logic signed [qav_pkg::RATE_W-1:0] rate_y,
  output logic signed [qav_pkg::RATE_W-1:0] rate_z,
  output logic saturated
);

  // front pipeline depth plus queue slots bounds the items in flight
  localparam int FRONT_LAT = 40 + CORDIC_STEPS;
  localparam int CREDITS = FRONT_LAT + qav_pkg::QUEUE_DEPTH;
  localparam int CNT_W = $clog2(CREDITS + 1);

  // time step register, seconds in unsigned q0.16
  logic [qav_pkg::TS_W-1:0] time_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      time_step <= qav_pkg::TIME_STEP_RESET;
    end else if (time_step_we) begin
      time_step <= time_step_wdata;
    end
  end

  // item accept and credit count of items not yet handed to the back end
  logic accept;
  logic pop;
  logic [CNT_W-1:0] credit;

  assign accept = start & ~busy;
  assign busy = (credit == CNT_W'(CREDITS));

  always_ff @(posedge clk) begin
    if (rst) begin
      credit <= '0;
    end else begin
      credit <= credit + CNT_W'(accept) - CNT_W'(pop);
    end
  end

  // front: quaternion difference, norm, angle and zero classification
  logic front_valid;
  qav_pkg::qav_item_t front_item;

  qav_front #(
    .COMPONENT_WIDTH(COMPONENT_WIDTH),
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .accept(accept),
    .first_w(first_w),
    .first_x(first_x),
    .first_y(first_y),
    .first_z(first_z),
    .second_w(second_w),
    .second_x(second_x),
    .second_y(second_y),
    .second_z(second_z),
    .force_short_path(force_short_path),
    .out_valid(front_valid),
    .out_item(front_item)
  );

  // queue decouples the two halves
  qav_pkg::qav_item_t head_item;
  qav_pkg::qav_queue_status_t queue_status;

  qav_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push(front_valid),
    .push_item(front_item),
    .pop(pop),
    .head_item(head_item),
    .status(queue_status)
  );

  // the back end takes an item every cycle one is waiting
  assign pop = ~queue_status.empty;

  // back: divisions, scaling and saturation
  qav_back u_back (
    .clk(clk),
    .rst(rst),
    .in_valid(pop),
    .in_item(head_item),
    .time_step(time_step),
    .done(done),
    .rate_x(rate_x),
    .rate_y(rate_y),
    .rate_z(rate_z),
    .saturated(saturated)
  );

  // credit count stays within its limit
  a_credit_bound : assert property (@(posedge clk) disable iff (rst)
    credit <= CNT_W'(CREDITS))
    else $error("credit count over limit");

  // the front never pushes into a full queue
  a_no_overflow : assert property (@(posedge clk) disable iff (rst)
    front_valid |-> !queue_status.full)
    else $error("push into full queue");

  // a saturated result holds a clipped component
  a_sat_clip : assert property (@(posedge clk) disable iff (rst)
    (done && saturated) |->
      (rate_x == 32'sh7FFF_FFFF || rate_x == 32'sh8000_0000 ||
       rate_y == 32'sh7FFF_FFFF || rate_y == 32'sh8000_0000 ||
       rate_z == 32'sh7FFF_FFFF || rate_z == 32'sh8000_0000))
    else $error("saturated without clipped component");

endmodule

`default_nettype wire

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// tb
// checks quaternion_angular_velocity against a cycle-free predictor of the
// rate computation, with bursty stimulus and several time step settings
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

  // what an entry of the pending list asks the driver to do
  typedef enum logic [1:0] {
    OP_ITEM,       // one orientation pair
    OP_TIME_STEP,  // write the time step register once the block is idle
    OP_SETTLE      // hold off until every expected rate has come back
  } op_kind_t;

  typedef struct {
    op_kind_t kind;
    logic [15:0] comp [8];  // first w,x,y,z then second w,x,y,z
    logic short_path;
    logic [15:0] ts_value;
  } pending_t;

  typedef struct {
    logic signed [31:0] rx;
    logic signed [31:0] ry;
    logic signed [31:0] rz;
    logic sat;
  } rate_t;

  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam longint unsigned RATE_POS_MAX = 64'd2147483647;
  localparam int WATCHDOG_LIMIT = 5000;

  // arctangent of 2^-i, Q2.30
  localparam longint ATAN_Q30 [16] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
    131072, 65536, 32768
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [15:0] first_w = '0, first_x = '0, first_y = '0, first_z = '0;
  logic signed [15:0] second_w = '0, second_x = '0, second_y = '0, second_z = '0;
  logic force_short_path = 1'b0;
  logic time_step_we = 1'b0;
  logic [15:0] time_step_wdata = '0;
  logic done;
  logic signed [31:0] rate_x, rate_y, rate_z;
  logic saturated;

  pending_t pending_q [$];
  rate_t expected_rates [$];
  logic [15:0] model_time_step;
  int mismatch_count = 0;
  bit stimulus_loaded = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  quaternion_angular_velocity DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .first_w(first_w),
    .first_x(first_x),
    .first_y(first_y),
    .first_z(first_z),
    .second_w(second_w),
    .second_x(second_x),
    .second_y(second_y),
    .second_z(second_z),
    .force_short_path(force_short_path),
    .time_step_we(time_step_we),
    .time_step_wdata(time_step_wdata),
    .done(done),
    .rate_x(rate_x),
    .rate_y(rate_y),
    .rate_z(rate_z),
    .saturated(saturated)
  );

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // Q1.31 product scaled down by 4, floor
  function automatic longint prod4(longint u, longint v);
    return (u * v) >>> 2;
  endfunction

  function automatic rate_t predict_rate(pending_t it, logic [15:0] ts);
    longint a [4];
    longint b [4];
    longint d [3];
    longint dw, dot, x, y, z, xs, ys, theta, v;
    longint unsigned rem, root, probe, q, dt, mag, r, m;
    rate_t res;
    res = '{default: '0};
    for (int k = 0; k < 4; k++) begin
      a[k] = longint'($signed(it.comp[k])) * 65536;
      b[k] = longint'($signed(it.comp[4 + k])) * 65536;
    end
    dot = prod4(a[0], b[0]) + prod4(a[1], b[1]) + prod4(a[2], b[2]) + prod4(a[3], b[3]);
    // shortest path: flip the second orientation when they point apart
    if (it.short_path && dot < 0)
      for (int k = 0; k < 4; k++) b[k] = -b[k];
    dw = prod4(b[0], a[0]) + prod4(b[1], a[1]) + prod4(b[2], a[2]) + prod4(b[3], a[3]);
    d[0] = -prod4(b[0], a[1]) + prod4(b[1], a[0]) - prod4(b[2], a[3]) + prod4(b[3], a[2]);
    d[1] = -prod4(b[0], a[2]) + prod4(b[1], a[3]) + prod4(b[2], a[0]) - prod4(b[3], a[1]);
    d[2] = -prod4(b[0], a[3]) - prod4(b[1], a[2]) + prod4(b[2], a[1]) + prod4(b[3], a[0]);
    dw = dw >>> 32;
    for (int k = 0; k < 3; k++) d[k] = d[k] >>> 32;

    // bitwise integer square root of the vector energy
    rem = longint'(d[0] * d[0]) + longint'(d[1] * d[1]) + longint'(d[2] * d[2]);
    root = 0;
    probe = 64'd1 << 62;
    while (probe > rem) probe = probe >> 2;
    while (probe != 0) begin
      if (rem >= root + probe) begin
        rem = rem - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    // no rotation axis: rates stay zero
    if (root == 0) return res;

    // vectoring cordic, left half plane pre-rotated by pi/2
    if (dw < 0) begin
      x = longint'(root);
      y = -dw;
      z = HALF_PI_Q30;
    end else begin
      x = dw;
      y = longint'(root);
      z = 0;
    end
    for (int i = 0; i < 16; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x = x + ys;
        y = y - xs;
        z = z + ATAN_Q30[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - ATAN_Q30[i];
      end
    end
    theta = 2 * z;
    // a zero or negative angle gives zero rates
    if (theta <= 0) return res;

    // a zero time step counts as one lsb
    dt = (ts == 0) ? 64'd1 : longint'(ts);
    q = (longint'(theta) * 4) / dt;
    for (int k = 0; k < 3; k++) begin
      mag = (d[k] < 0) ? longint'(-d[k]) : longint'(d[k]);
      r = (mag << 28) / root;
      m = (r * q) >> 28;
      if (d[k] < 0) begin
        if (m > RATE_POS_MAX + 1) begin
          m = RATE_POS_MAX + 1;
          res.sat = 1'b1;
        end
        v = -longint'(m);
      end else begin
        if (m > RATE_POS_MAX) begin
          m = RATE_POS_MAX;
          res.sat = 1'b1;
        end
        v = longint'(m);
      end
      case (k)
        0: res.rx = v[31:0];
        1: res.ry = v[31:0];
        default: res.rz = v[31:0];
      endcase
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic logic [15:0] to_q15(real v);
    real s;
    s = v * 32768.0;
    if (s > 32767.0) s = 32767.0;
    if (s < -32768.0) s = -32768.0;
    return 16'($rtoi(s));
  endfunction

  function automatic real rand_unit_real();
    return ($itor($urandom_range(0, 20000)) - 10000.0) / 10000.0;
  endfunction

  task automatic push_item(logic [15:0] c0, logic [15:0] c1, logic [15:0] c2,
                           logic [15:0] c3, logic [15:0] c4, logic [15:0] c5,
                           logic [15:0] c6, logic [15:0] c7, logic fsp);
    pending_t p;
    p.kind = OP_ITEM;
    p.comp = '{c0, c1, c2, c3, c4, c5, c6, c7};
    p.short_path = fsp;
    p.ts_value = '0;
    pending_q.push_back(p);
  endtask

  task automatic push_op(op_kind_t kind, logic [15:0] value);
    pending_t p;
    p.kind = kind;
    p.comp = '{default: '0};
    p.short_path = 1'b0;
    p.ts_value = value;
    pending_q.push_back(p);
  endtask

  // a realistic pair: unit q1 and a q2 perturbed by spread, renormalized;
  // the sign of q2 is flipped at random to exercise the short path
  task automatic push_unit_pair(real spread);
    real a [4];
    real b [4];
    real na, nb;
    logic [15:0] ca [4];
    logic [15:0] cb [4];
    bit flip;
    na = 0.0;
    nb = 0.0;
    for (int k = 0; k < 4; k++) begin
      a[k] = rand_unit_real();
      na += a[k] * a[k];
    end
    if (na < 1e-6) begin
      a[0] = 1.0;
      na = 1.0;
    end
    na = $sqrt(na);
    for (int k = 0; k < 4; k++) begin
      a[k] = a[k] / na;
      b[k] = a[k] + spread * rand_unit_real();
      nb += b[k] * b[k];
    end
    nb = $sqrt(nb);
    flip = $urandom_range(0, 3) == 0;
    for (int k = 0; k < 4; k++) begin
      ca[k] = to_q15(a[k] * 0.99997);
      cb[k] = to_q15((flip ? -b[k] : b[k]) / nb * 0.99997);
    end
    push_item(ca[0], ca[1], ca[2], ca[3], cb[0], cb[1], cb[2], cb[3],
              1'($urandom_range(0, 1)));
  endtask

  task automatic push_random_phase(int count);
    real spread;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 9))
        0, 1: // raw noise over the full field range, not unit length
          push_item(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                    16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                    1'($urandom_range(0, 1)));
        2: // tiny rotations near the one lsb norm limit
          push_unit_pair(0.0002);
        default: begin
          spread = (($urandom_range(0, 1)) != 0) ? 0.05 : 1.0;
          push_unit_pair(spread);
        end
      endcase
    end
  endtask

  // ---------------------------------------------------------------------------
  // stimulus plan
  // ---------------------------------------------------------------------------
  initial begin
    // identity to identity: zero norm
    push_item(16'h7FFF, 0, 0, 0, 16'h7FFF, 0, 0, 0, 1'b0);
    // same orientation twice, not identity
    push_item(16'h4000, 16'h4000, 16'h4000, 16'h4000,
              16'h4000, 16'h4000, 16'h4000, 16'h4000, 1'b1);
    // quarter turns about each axis
    push_item(16'h7FFF, 0, 0, 0, 16'h5A82, 16'h5A82, 0, 0, 1'b0);
    push_item(16'h7FFF, 0, 0, 0, 16'h5A82, 0, 16'hA57E, 0, 1'b0);
    push_item(16'h7FFF, 0, 0, 0, 16'h5A82, 0, 0, 16'h5A82, 1'b0);
    // half turn, scalar of the difference near zero
    push_item(16'h7FFF, 0, 0, 0, 0, 16'h7FFF, 0, 0, 1'b0);
    // long way round: negative dot with and without the short path
    push_item(16'h7FFF, 0, 0, 0, 16'hA57E, 16'hA57E, 0, 0, 1'b0);
    push_item(16'h7FFF, 0, 0, 0, 16'hA57E, 16'hA57E, 0, 0, 1'b1);
    // q2 = -q1: same attitude, negative scalar part
    push_item(16'h7FFF, 0, 0, 0, 16'h8001, 0, 0, 0, 1'b0);
    push_item(16'h7FFF, 0, 0, 0, 16'h8001, 0, 0, 0, 1'b1);
    // field extremes, non-unit
    push_item(16'h8000, 16'h8000, 16'h8000, 16'h8000,
              16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b1);
    push_item(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
              16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b0);
    push_item(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF,
              16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 1'b1);
    push_item(0, 0, 0, 0, 0, 0, 0, 0, 1'b1);
    push_item(16'h7FFF, 0, 0, 0, 16'h7FFF, 16'h0001, 0, 0, 1'b0);
    push_item(16'h7FFF, 0, 0, 0, 16'h7FFF, 0, 16'hFFFF, 16'h0001, 1'b1);
    push_item(16'h8000, 0, 0, 0, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0);

    // random content under several time steps, extremes included
    push_random_phase(300);
    push_op(OP_SETTLE, '0);
    push_random_phase(100);
    push_op(OP_TIME_STEP, 16'd1);
    push_item(16'h7FFF, 0, 0, 0, 0, 16'h7FFF, 0, 0, 1'b0);
    push_random_phase(150);
    push_op(OP_TIME_STEP, 16'hFFFF);
    push_item(16'h7FFF, 0, 0, 0, 16'h7FFF, 16'h0001, 0, 0, 1'b0);
    push_random_phase(200);
    push_op(OP_TIME_STEP, 16'd0);
    push_item(16'h7FFF, 0, 0, 0, 16'h5A82, 16'h5A82, 0, 0, 1'b0);
    push_random_phase(100);
    push_op(OP_TIME_STEP, 16'($urandom_range(2, 600)));
    push_random_phase(200);
    push_op(OP_TIME_STEP, 16'($urandom_range(1, 65535)));
    push_random_phase(180);
    stimulus_loaded = 1'b1;
  end

  // ---------------------------------------------------------------------------
  // driver: bursts of items with random gaps, register writes only when idle
  // ---------------------------------------------------------------------------
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    pending_t nxt;
    bit accepted;
    bit load_next;
    if (rst) begin
      model_time_step <= 16'd6554;
      start <= 1'b0;
      time_step_we <= 1'b0;
    end else begin
      accepted = start && !busy;
      // register write lands at this edge
      if (time_step_we) model_time_step <= time_step_wdata;
      if (accepted) begin
        expected_rates.push_back(predict_rate(pending_q.pop_front(), model_time_step));
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 40);
          // some bursts run back to back with no gap at all
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
        end
      end
      load_next = 1'b0;
      if (time_step_we) begin
        time_step_we <= 1'b0;
      end else if (start && !accepted) begin
        // item held until the block takes it
      end else if (pending_q.size() == 0) begin
        start <= 1'b0;
      end else begin
        nxt = pending_q[0];
        if (nxt.kind != OP_ITEM) begin
          start <= 1'b0;
          // idle means nothing outstanding and no item on the port
          if (expected_rates.size() == 0 && !accepted) begin
            void'(pending_q.pop_front());
            if (nxt.kind == OP_TIME_STEP) begin
              time_step_wdata <= nxt.ts_value;
              time_step_we <= 1'b1;
            end
          end
        end else if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else begin
          load_next = 1'b1;
        end
      end
      if (load_next) begin
        start <= 1'b1;
        first_w <= pending_q[0].comp[0];
        first_x <= pending_q[0].comp[1];
        first_y <= pending_q[0].comp[2];
        first_z <= pending_q[0].comp[3];
        second_w <= pending_q[0].comp[4];
        second_x <= pending_q[0].comp[5];
        second_y <= pending_q[0].comp[6];
        second_z <= pending_q[0].comp[7];
        force_short_path <= pending_q[0].short_path;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: every done strobe is checked against the oldest expected rate
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string what, logic signed [31:0] got,
                                 logic signed [31:0] want);
    $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    rate_t want;
    if (!rst && done) begin
      if (expected_rates.size() == 0) begin
        report_mismatch("unexpected item", rate_x, 0);
      end else begin
        want = expected_rates.pop_front();
        if (rate_x !== want.rx) report_mismatch("rate_x", rate_x, want.rx);
        if (rate_y !== want.ry) report_mismatch("rate_y", rate_y, want.ry);
        if (rate_z !== want.rz) report_mismatch("rate_z", rate_z, want.rz);
        if (saturated !== want.sat)
          report_mismatch("saturated", 32'(saturated), 32'(want.sat));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: too long without any item moving on either side
  // ---------------------------------------------------------------------------
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || time_step_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired");
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // reset, then wait for the plan to run dry and the pipe to drain
  // ---------------------------------------------------------------------------
  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    wait (stimulus_loaded);
    @(posedge clk);
    while (pending_q.size() != 0 || start || expected_rates.size() != 0) @(posedge clk);
    // catch any stray strobe
    repeat (150) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
